// ===== rtl/sais_pkg.sv =====
`default_nettype none

package sais_pkg;

  localparam int unsigned OP_W          = 2;
  localparam int unsigned KEY_FIELD_W   = 32;
  localparam int unsigned INDEX_W       = 6;
  localparam int unsigned STATUS_W      = 3;
  localparam int unsigned COUNT_FIELD_W = 7;
  localparam int unsigned REG_INDEX_W   = 2;
  localparam int unsigned REG_DATA_W    = 32;

  localparam logic [REG_INDEX_W-1:0] REG_KEEP_SORTED = 2'd0;
  localparam logic [REG_INDEX_W-1:0] REG_CHECK_DUP   = 2'd1;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_RANGE    = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_e;

  typedef struct packed {
    op_e                    operation;
    logic [KEY_FIELD_W-1:0] key;
    logic [INDEX_W-1:0]     entry_index;
  } in_item_t;

  typedef struct packed {
    status_e                  status;
    logic [INDEX_W-1:0]       result_index;
    logic [KEY_FIELD_W-1:0]   result_key;
    logic [COUNT_FIELD_W-1:0] stored_count;
  } out_item_t;

  typedef struct packed {
    logic [REG_INDEX_W-1:0] reg_index;
    logic [REG_DATA_W-1:0]  wdata;
  } cfg_item_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic init;
    logic advance;
    logic insert;
  } cell_ctrl_t;

  // compare flags of the cell holding the token
  typedef struct packed {
    logic eq;
    logic gt;
  } cell_hit_t;

endpackage

`default_nettype wire

// ===== rtl/sais_chan_if.sv =====
`default_nettype none

interface sais_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/sais_cell.sv =====
`default_nettype none

module sais_cell #(
  parameter int unsigned KEY_WIDTH = 32
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  sais_pkg::cell_ctrl_t ctrl_i,
  input  wire [KEY_WIDTH-1:0]  probe_key_i,
  input  wire                  front_left_i,
  input  wire [KEY_WIDTH-1:0]  key_left_i,
  output logic                 front_o,
  output logic [KEY_WIDTH-1:0] key_o,
  output logic                 hit_eq_o,
  output logic                 hit_gt_o,
  output logic [KEY_WIDTH-1:0] sel_key_o
);
  import sais_pkg::*;

  logic                 front_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic                 tok;

  // token sits at the first cell of the not-yet-visited front
  assign tok = front_q & ~front_left_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= 1'b0;
    end else if (ctrl_i.init) begin
      front_q <= 1'b1;
    end else if (ctrl_i.advance) begin
      front_q <= front_left_i;
    end
  end

  // insert: token cell takes the new key, cells above take their left neighbor
  always_ff @(posedge clk_i) begin
    if (ctrl_i.insert && front_q) begin
      key_q <= tok ? probe_key_i : key_left_i;
    end
  end

  assign front_o   = front_q;
  assign key_o     = key_q;
  assign hit_eq_o  = tok & (key_q == probe_key_i);
  assign hit_gt_o  = tok & (probe_key_i < key_q);
  assign sel_key_o = tok ? key_q : '0;

endmodule

`default_nettype wire

// ===== rtl/sais_chain.sv =====
`default_nettype none

module sais_chain #(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  sais_pkg::cell_ctrl_t ctrl_i,
  input  wire [KEY_WIDTH-1:0]  probe_key_i,
  output sais_pkg::cell_hit_t  hit_o,
  output logic [KEY_WIDTH-1:0] sel_key_o
);
  import sais_pkg::*;

  logic [CAPACITY-1:0]  front;
  logic [CAPACITY-1:0]  eq_vec;
  logic [CAPACITY-1:0]  gt_vec;
  logic [KEY_WIDTH-1:0] cell_key [CAPACITY];
  logic [KEY_WIDTH-1:0] sel_key  [CAPACITY];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                 front_left;
    logic [KEY_WIDTH-1:0] key_left;

    if (g == 0) begin : g_first
      assign front_left = 1'b0;
      assign key_left   = '0;
    end else begin : g_rest
      assign front_left = front[g-1];
      assign key_left   = cell_key[g-1];
    end

    sais_cell #(
      .KEY_WIDTH (KEY_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl_i),
      .probe_key_i  (probe_key_i),
      .front_left_i (front_left),
      .key_left_i   (key_left),
      .front_o      (front[g]),
      .key_o        (cell_key[g]),
      .hit_eq_o     (eq_vec[g]),
      .hit_gt_o     (gt_vec[g]),
      .sel_key_o    (sel_key[g])
    );
  end

  assign hit_o.eq = |eq_vec;
  assign hit_o.gt = |gt_vec;

  // only the token cell drives a nonzero key
  always_comb begin
    sel_key_o = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_key_o = sel_key_o | sel_key[i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_array_set_insert_find_top.sv =====
// Operation: an item is accepted in idle and its result is registered once the
//   token stops at cell p (0 up to CAPACITY) and the output register is free.
// Flow: a token walks the cell chain one cell per cycle until it stops, so the
//   scan length sets the rate; a new item is taken only in idle. A result waiting
//   in the output register does not block acceptance of the next item.
// Reset: key count cleared, keep_sorted and check_duplicates set; stored keys
//   stay undefined until written, with no clearing pass.
`default_nettype none

module sorted_array_set_insert_find_top #(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  wire   clk_i,
  input  wire   rst_ni,
  sais_chan_if.sink   cfg_i,
  sais_chan_if.sink   in_i,
  sais_chan_if.source out_o
);
  import sais_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  state_e               state_q, state_d;
  op_e                  op_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [INDEX_W-1:0]   idx_q;
  logic [CW-1:0]        pos_q, pos_d;
  logic [CW-1:0]        count_q, count_d;
  logic                 keep_sorted_q;
  logic                 check_dup_q;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, out_d;

  cell_ctrl_t           ctrl;
  cell_hit_t            hit;
  logic [KEY_WIDTH-1:0] sel_key;

  logic                 done;
  logic                 ins;
  logic                 clr;
  logic                 at_end;
  status_e              res_status;
  logic [CW-1:0]        res_index;
  logic [KEY_WIDTH-1:0] res_key;
  logic                 in_fire;

  sais_chain #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .probe_key_i (key_q),
    .hit_o       (hit),
    .sel_key_o   (sel_key)
  );

  assign cfg_i.ready   = 1'b1;
  assign in_i.ready    = (state_q == S_IDLE);
  assign in_fire       = in_i.valid & in_i.ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_sorted_q <= 1'b1;
      check_dup_q   <= 1'b1;
    end else if (cfg_i.valid) begin
      case (cfg_i.payload.reg_index)
        REG_KEEP_SORTED: keep_sorted_q <= cfg_i.payload.wdata[0];
        REG_CHECK_DUP:   check_dup_q   <= cfg_i.payload.wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= in_i.payload.operation;
      key_q <= KEY_WIDTH'(in_i.payload.key);
      idx_q <= in_i.payload.entry_index;
    end
    out_q <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    count_d     = count_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    out_d       = out_q;
    ctrl        = '0;
    done        = 1'b0;
    ins         = 1'b0;
    clr         = 1'b0;
    res_status  = ST_OK;
    res_index   = pos_q;
    res_key     = '0;
    at_end      = (pos_q == count_q);

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          ctrl.init = 1'b1;
          pos_d     = '0;
          state_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        unique case (op_q)
          OP_INSERT: begin
            if (!at_end && (keep_sorted_q || check_dup_q) && hit.eq) begin
              done       = 1'b1;
              res_status = ST_DUP;
            end else if (at_end || (keep_sorted_q && hit.gt)) begin
              done = 1'b1;
              if (count_q == CAP_C) begin
                res_status = ST_FULL;
                res_index  = '0;
              end else begin
                ins = 1'b1;
              end
            end
          end
          OP_FIND: begin
            if (at_end) begin
              done       = 1'b1;
              res_status = ST_NOTFOUND;
              res_index  = '0;
            end else if (hit.eq) begin
              done = 1'b1;
            end
          end
          OP_READ: begin
            res_index = '0;
            if (IW'(idx_q) >= IW'(count_q)) begin
              done       = 1'b1;
              res_status = ST_RANGE;
            end else if (IW'(pos_q) == IW'(idx_q)) begin
              done    = 1'b1;
              res_key = sel_key;
            end
          end
          OP_CLEAR: begin
            done      = 1'b1;
            clr       = 1'b1;
            res_index = '0;
          end
        endcase

        if (done) begin
          // hold the finished result until the output register frees up
          if (!out_valid_q || out_o.ready) begin
            ctrl.insert = ins;
            if (clr) begin
              count_d = '0;
            end else if (ins) begin
              count_d = count_q + 1'b1;
            end
            out_valid_d        = 1'b1;
            out_d.status       = res_status;
            out_d.result_index = INDEX_W'(res_index);
            out_d.result_key   = KEY_FIELD_W'(res_key);
            out_d.stored_count = COUNT_FIELD_W'(count_d);
            state_d            = S_IDLE;
          end
        end else begin
          ctrl.advance = 1'b1;
          pos_d        = pos_q + 1'b1;
        end
      end
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_C)
    else $error("key count exceeds capacity");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (pos_q <= count_q))
    else $error("token walked past the last held key");

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_SCAN) && (pos_q == '0))
    else $error("accepted transaction did not start a scan at cell zero");

  a_result_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_SCAN))
    else $error("result raised without a scan");
`endif

endmodule

`default_nettype wire
